[hw/rtl/sitoa_pkg.sv]
// shared constants and helpers for the signed integer to decimal text converter
// no dependencies
package sitoa_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int IN_BITS         = 32;
    localparam int CHAR_BITS       = 8;

    localparam logic [CHAR_BITS-1:0] DIGIT_ZERO = 8'd48;
    localparam logic [CHAR_BITS-1:0] DIGIT_NINE = 8'd57;
    localparam logic [CHAR_BITS-1:0] MINUS_CODE = 8'd45;

    // decimal digits needed for a magnitude of up to 2^(vb-1), log10(2) ~ 1233/4096
    function automatic int bcd_digits(input int vb);
        return ((vb * 1233) >> 12) + 1;
    endfunction

endpackage

[hw/rtl/sitoa_fifo.sv]
// small register queue between the front and the back of the converter
// uses sitoa_pkg
module sitoa_fifo
    import sitoa_pkg::*;
#(
    parameter int WIDTH = VALUE_BITS_DEF + 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/sitoa_front.sv]
// input side: takes a word, splits it into sign and magnitude, pushes to the queue
// uses sitoa_pkg and sitoa_fifo
module sitoa_front
    import sitoa_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_BITS-1:0]    s_tdata,
    input  logic                  q_pop,
    output logic                  q_valid,
    output logic                  q_neg,
    output logic [VALUE_BITS-1:0] q_mag
);

    logic [VALUE_BITS+IN_BITS-1:0] wide;
    logic [VALUE_BITS-1:0]         raw;
    logic                          neg;
    logic [VALUE_BITS-1:0]         mag;
    logic                          q_full;
    logic [VALUE_BITS:0]           q_data;

    // bits above VALUE_BITS are dropped, missing upper bits read as zero
    assign wide = (VALUE_BITS + IN_BITS)'(s_tdata);
    assign raw  = wide[VALUE_BITS-1:0];
    assign neg  = raw[VALUE_BITS-1];
    assign mag  = neg ? (~raw + 1'b1) : raw;

    assign s_tready = !q_full;
    assign q_neg    = q_data[VALUE_BITS];
    assign q_mag    = q_data[VALUE_BITS-1:0];

    sitoa_fifo #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data ({neg, mag}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

endmodule

[hw/rtl/sitoa_back.sv]
// back side: binary to bcd by shift and add-3, then emits sign and digits
// uses sitoa_pkg
module sitoa_back
    import sitoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  logic                  q_neg,
    input  logic [VALUE_BITS-1:0] q_mag,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CHAR_BITS-1:0]  m_tdata,
    output logic                  m_tlast
);

    localparam int NDIG     = bcd_digits(VALUE_BITS);
    localparam int BCD_BITS = NDIG * 4;
    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam int IDX_BITS = $clog2(NDIG);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t                state_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic                  neg_reg;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [CNT_BITS-1:0]   bit_cnt_reg;
    logic [IDX_BITS-1:0]   idx_reg;

    logic [BCD_BITS-1:0]   bcd_adj;
    logic [IDX_BITS-1:0]   top_idx;
    logic [3:0]            cur_digit;
    logic                  out_free;
    logic                  load_char;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                           : bcd_reg[i*4 +: 4];
        end
    end

    // highest nonzero digit, zero gives index 0
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                top_idx = IDX_BITS'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign out_free  = !m_tvalid || m_tready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    // a new word goes into the output register this cycle
    assign load_char = ((state_reg == ST_SIGN) || (state_reg == ST_DIGITS)) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
            idx_reg     <= '0;
            m_tvalid    <= 1'b0;
            m_tdata     <= '0;
            m_tlast     <= 1'b0;
        end
        else
        begin
            if (load_char)
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        mag_reg     <= q_mag;
                        neg_reg     <= q_neg;
                        bcd_reg     <= '0;
                        bit_cnt_reg <= CNT_BITS'(VALUE_BITS - 1);
                        state_reg   <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    bcd_reg <= {bcd_adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
                    mag_reg <= mag_reg << 1;
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= ST_FIND;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                end
                ST_FIND:
                begin
                    idx_reg   <= top_idx;
                    state_reg <= neg_reg ? ST_SIGN : ST_DIGITS;
                end
                ST_SIGN:
                begin
                    if (out_free)
                    begin
                        m_tdata   <= MINUS_CODE;
                        m_tlast   <= 1'b0;
                        state_reg <= ST_DIGITS;
                    end
                end
                ST_DIGITS:
                begin
                    if (out_free)
                    begin
                        m_tdata  <= DIGIT_ZERO + CHAR_BITS'(cur_digit);
                        m_tlast  <= (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == MINUS_CODE) ||
                     ((m_tdata >= DIGIT_ZERO) && (m_tdata <= DIGIT_NINE)))
        else $error("output word is neither a digit nor a minus sign");

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata != MINUS_CODE))
        else $error("minus sign flagged as last word");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_CONV) && (bcd_reg == '0))
        else $error("queue pop did not start a conversion");

    a_sign_needs_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |-> neg_reg)
        else $error("sign state entered for a non-negative value");

endmodule

[hw/rtl/signed_int_to_decimal_ascii.sv]
// top level of the signed integer to decimal text converter
// uses sitoa_pkg, sitoa_front (with sitoa_fifo) and sitoa_back
//
//  channel | dir | payload
//  s_*     | in  | tdata[31:0] value (signed)
//  m_*     | out | tdata[7:0] char_code, tlast last_char
//
// one input word gives up to 11 output words at 32 bits (sign plus digits)
// per item: the back takes the word from the queue, runs one shift/add-3 step
// per magnitude bit in the bcd converter, finds the top digit, then sends one
// char per cycle unless the output stalls; the queue takes new words while the
// back converts; rst_n clears all control; a stalled output word holds the back
// in place until taken
module signed_int_to_decimal_ascii
    import sitoa_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_BITS-1:0]   s_tdata,   // [31:0] value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAR_BITS-1:0] m_tdata,   // [7:0] char_code
    output logic                 m_tlast
);

    logic                  q_pop;
    logic                  q_valid;
    logic                  q_neg;
    logic [VALUE_BITS-1:0] q_mag;

    sitoa_front #(
        .VALUE_BITS  (VALUE_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_neg    (q_neg),
        .q_mag    (q_mag)
    );

    sitoa_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_neg    (q_neg),
        .q_mag    (q_mag),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/sitoa_checker.sv]
// watches both streams of the signed integer to decimal text converter,
// predicts the character words of each value and compares them in order
// depends on sitoa_pkg
module sitoa_checker
    import sitoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_BITS-1:0]   s_tdata,   // [31:0] value
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [CHAR_BITS-1:0] m_tdata,   // [7:0] char_code
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   chars_pending,
    output int                   values_seen,
    output int                   negatives_seen,
    output int                   chars_seen
);

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 last;
    } text_char_t;

    text_char_t expected_text[$];

    initial
    begin
        fail_count     = 0;
        chars_pending  = 0;
        values_seen    = 0;
        negatives_seen = 0;
        chars_seen     = 0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    // decimal text of the low VALUE_BITS bits taken as two's complement
    function automatic void predict_text(input logic [IN_BITS-1:0] word);
        longint unsigned mask;
        longint unsigned raw;
        longint unsigned magnitude;
        bit              negative;
        logic [3:0]      digit_buf[$];
        text_char_t      ch;
        mask      = (64'd1 << VALUE_BITS) - 64'd1;
        raw       = longint'({32'b0, word}) & mask;
        negative  = raw[VALUE_BITS-1];
        magnitude = negative ? ((~raw + 64'd1) & mask) : raw;
        do
        begin
            digit_buf.push_front(4'(magnitude % 10));
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);
        if (negative)
        begin
            ch.code = MINUS_CODE;
            ch.last = 1'b0;
            expected_text.push_back(ch);
            negatives_seen++;
        end
        foreach (digit_buf[i])
        begin
            ch.code = DIGIT_ZERO + CHAR_BITS'(digit_buf[i]);
            ch.last = (i == digit_buf.size() - 1);
            expected_text.push_back(ch);
        end
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_text(s_tdata);
                values_seen++;
            end
            if (m_tvalid && m_tready)
            begin
                chars_seen++;
                if (expected_text.size() == 0)
                    report_mismatch($sformatf("unexpected char word 0x%02h last %0b",
                                              m_tdata, m_tlast));
                else
                begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.code)
                        report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                                  m_tdata, want.code));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last_char %0b, expected %0b on 0x%02h",
                                                  m_tlast, want.last, want.code));
                end
            end
            chars_pending = expected_text.size();
        end
    end

endmodule

[tb/testbench.sv]
// stimulus and verdict for the signed integer to decimal text converter
// depends on sitoa_pkg, signed_int_to_decimal_ascii and sitoa_checker
module testbench;
    import sitoa_pkg::*;

    localparam int RANDOM_VALUES = 90;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 60;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_BITS-1:0]   s_tdata  = '0;   // [31:0] value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CHAR_BITS-1:0] m_tdata;         // [7:0] char_code
    logic                 m_tlast;

    int fail_count;
    int chars_pending;
    int values_seen;
    int negatives_seen;
    int chars_seen;

    bit no_gaps      = 1'b0;
    bit hold_request = 1'b0;

    logic [IN_BITS-1:0] directed_values [20] = '{
        32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
        -32'sd1000000000, 32'd999999999, 32'h5555_5555, 32'haaaa_aaaa,
        32'd12345, -32'sd98765, 32'h7fff_fffe, -32'sd1
    };

    always #6 clk = ~clk;

    signed_int_to_decimal_ascii u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sitoa_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .chars_pending  (chars_pending),
        .values_seen    (values_seen),
        .negatives_seen (negatives_seen),
        .chars_seen     (chars_seen)
    );

    // offer one word after a random gap, or none while no_gaps is set, and wait for it to be taken
    task automatic send_value(input logic [IN_BITS-1:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // mix of full-range words, short numbers, powers of ten and the edges
    function automatic logic [IN_BITS-1:0] random_value();
        logic [IN_BITS-1:0] v;
        int                 exponent;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 999);
            2:
            begin
                v = 1;
                exponent = $urandom_range(0, 9);
                repeat (exponent) v = v * 10;
                v = v - $urandom_range(0, 1);
            end
            default: v = $urandom_range(0, 20) + ($urandom_range(0, 1) ? 32'h8000_0000 : 0);
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_values[i])
            send_value(directed_values[i]);
        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            no_gaps = (i >= 30 && i < 50);
            // output side holds off while words keep coming
            if (i == 70)
                hold_request = 1'b1;
            send_value(random_value());
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;
        // let the checker pick up the last accepted word first
        @(posedge clk);
        while (chars_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("converted %0d values (%0d negative) into %0d characters",
                 values_seen, negatives_seen, chars_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : char_sink
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        #2000000;
        $display("timeout at %0t", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sitoa_pkg.sv
hw/rtl/sitoa_fifo.sv
hw/rtl/sitoa_front.sv
hw/rtl/sitoa_back.sv
hw/rtl/signed_int_to_decimal_ascii.sv
tb/sitoa_checker.sv
tb/testbench.sv
